// ===== design/evh_pkg.sv =====
// Shared widths, item types and codes of the energy detector with hangover.
`timescale 1ns / 1ps

package evh_pkg;

  localparam int FRAME_SAMPLES = 512;
  localparam int SAMPLE_W      = 16;
  localparam int SQ_W          = 31;
  localparam int ENERGY_W      = 31;
  localparam int RUN_W         = 16;
  localparam int SUM_W         = SQ_W + $clog2(FRAME_SAMPLES);
  localparam int CNT_W         = $clog2(FRAME_SAMPLES + 1);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  localparam int FQ_DEPTH  = 4;
  localparam int FQ_PTR_W  = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W  = $clog2(FQ_DEPTH + 1);
  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [ENERGY_W-1:0] THRESHOLD_RESET     = ENERGY_W'(2000);
  localparam logic [RUN_W-1:0]    SILENCE_LIMIT_RESET = RUN_W'(30);

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_END   = 2'd2
  } vad_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_SILENCE_LIMIT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          vad_event;
    logic                frame_speech;
    logic [ENERGY_W-1:0] frame_energy;
    logic                in_speech_now;
  } result_t;

  // One completed frame on its way from the front to the back.
  typedef struct packed {
    logic             restart;
    logic [SUM_W-1:0] sum;
  } frame_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

endpackage

// ===== design/evh_front.sv =====
// Front end: takes samples, squares them and sums each frame.
`timescale 1ns / 1ps

module evh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  evh_pkg::in_item_t sample_item,
  output logic              fq_push,
  output evh_pkg::frame_t   fq_data,
  input  logic              fq_full
);
  import evh_pkg::*;

  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_inc;
  logic                   accept;
  logic                   in_last;
  logic signed [2*SAMPLE_W-1:0] prod;

  logic                   s_valid;
  logic                   s_last;
  logic                   s_restart;
  logic [SQ_W-1:0]        s_sq;

  logic [SUM_W-1:0]       acc;
  logic [SUM_W-1:0]       acc_base;
  logic [SUM_W-1:0]       acc_next;
  logic                   pend;
  logic                   pend_next;

  // The front only stalls when a finished frame cannot enter the queue.
  assign full    = s_valid & s_last & fq_full;
  assign accept  = push & ~full;

  assign cnt_inc = (sample_item.restart ? '0 : cnt) + 1'b1;
  assign in_last = (cnt_inc == CNT_W'(FRAME_SAMPLES));
  assign prod    = sample_item.sample * sample_item.sample;

  assign acc_base  = s_restart ? '0 : acc;
  assign acc_next  = acc_base + SUM_W'(s_sq);
  assign pend_next = pend | s_restart;

  assign fq_push      = s_valid & s_last & ~full;
  assign fq_data.restart = pend_next;
  assign fq_data.sum     = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      cnt     <= '0;
      acc     <= '0;
      pend    <= 1'b0;
    end else if (!full) begin
      s_valid <= accept;
      if (accept) begin
        cnt <= in_last ? '0 : cnt_inc;
      end
      if (s_valid) begin
        if (s_last) begin
          acc  <= '0;
          pend <= 1'b0;
        end else begin
          acc  <= acc_next;
          pend <= pend_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_sq      <= prod[SQ_W-1:0];
      s_last    <= in_last;
      s_restart <= sample_item.restart;
    end
  end

endmodule

// ===== design/evh_frame_fifo.sv =====
// Short queue of completed frame sums between the front and the back.
`timescale 1ns / 1ps

module evh_frame_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  evh_pkg::frame_t wdata,
  output logic            full,
  input  logic            pop,
  output evh_pkg::frame_t rdata,
  output logic            empty
);
  import evh_pkg::*;

  frame_t              mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr;
  logic [FQ_PTR_W-1:0] rd_ptr;
  logic [FQ_CNT_W-1:0] count;

  assign full  = (count == FQ_CNT_W'(FQ_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FQ_CNT_W'(push) - FQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== design/evh_back.sv =====
// Back end: frame decision, hangover state, registers and the result queue.
`timescale 1ns / 1ps

module evh_back (
  input  logic                clk,
  input  logic                rst,
  input  evh_pkg::cfg_write_t cfg,
  input  logic                fq_empty,
  input  evh_pkg::frame_t     fq_data,
  output logic                fq_pop,
  output logic                empty,
  input  logic                pop,
  output evh_pkg::result_t    result
);
  import evh_pkg::*;

  localparam logic [SUM_W-1:0] FRAME_DIV = SUM_W'(FRAME_SAMPLES);

  logic [ENERGY_W-1:0]  threshold;
  logic [RUN_W-1:0]     silence_limit;
  logic                 speech_flag;
  logic                 speech_flag_next;
  logic [RUN_W-1:0]     silent_run;
  logic [RUN_W-1:0]     silent_run_next;

  logic                 flag_base;
  logic [RUN_W-1:0]     run_base;
  logic [RUN_W-1:0]     run_inc;
  logic [ENERGY_W-1:0]  energy;
  logic                 frame_loud;
  vad_event_t           event_code;
  result_t              res;

  result_t              oq [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] oq_wr;
  logic [OUT_PTR_W-1:0] oq_rd;
  logic [OUT_CNT_W-1:0] oq_count;
  logic                 oq_full;
  logic                 oq_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RESET;
      silence_limit <= SILENCE_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_THRESHOLD:     threshold     <= cfg.data[ENERGY_W-1:0];
        REG_SILENCE_LIMIT: silence_limit <= cfg.data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  assign oq_full = (oq_count == OUT_CNT_W'(OUT_DEPTH));
  assign fq_pop  = ~fq_empty & ~oq_full;
  assign oq_pop  = pop & ~empty;

  assign energy     = ENERGY_W'(fq_data.sum / FRAME_DIV);
  assign frame_loud = energy > threshold;
  assign flag_base  = fq_data.restart ? 1'b0 : speech_flag;
  assign run_base   = fq_data.restart ? '0 : silent_run;
  assign run_inc    = run_base + 1'b1;

  always_comb begin
    event_code       = EV_NONE;
    speech_flag_next = flag_base;
    silent_run_next  = run_base;
    if (frame_loud) begin
      silent_run_next = '0;
      if (!flag_base) begin
        speech_flag_next = 1'b1;
        event_code       = EV_START;
      end
    end else if (flag_base) begin
      if (run_inc >= silence_limit) begin
        speech_flag_next = 1'b0;
        silent_run_next  = '0;
        event_code       = EV_END;
      end else begin
        silent_run_next = run_inc;
      end
    end
  end

  assign res.vad_event     = event_code;
  assign res.frame_speech  = frame_loud;
  assign res.frame_energy  = energy;
  assign res.in_speech_now = speech_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      speech_flag <= 1'b0;
      silent_run  <= '0;
      oq_wr       <= '0;
      oq_rd       <= '0;
      oq_count    <= '0;
    end else begin
      if (fq_pop) begin
        speech_flag <= speech_flag_next;
        silent_run  <= silent_run_next;
        oq_wr       <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      oq_count <= oq_count + OUT_CNT_W'(fq_pop) - OUT_CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (fq_pop) begin
      oq[oq_wr] <= res;
    end
  end

  assign empty  = (oq_count == '0);
  assign result = oq[oq_rd];

endmodule

// ===== design/energy_vad_hangover_unit.sv =====
// Top level of the energy-threshold voice activity detector with hangover.
// Usage:
// Samples enter through a queue-like port: an item is taken at a clock edge with push
// high and full low. Each item carries one signed 16-bit sample and a restart bit;
// restart drops the partial frame and closes any open speech segment before the
// sample is counted. After every FRAME_SAMPLES samples one result item appears on
// the result port, the oldest first, while empty is low; it is taken with pop.
// The front squares and sums one sample per cycle while full is low, so samples may
// be pushed in every cycle. A result passes the sample register and both queues
// before it is visible. The back makes one frame decision per cycle while the result
// queue has room, far faster than frames arrive. If the receiver stops popping,
// finished results wait in a two-entry result queue and frame sums in a four-entry
// frame queue; only when both are full does full rise, and then just on the last
// sample of a frame. The two registers, threshold (index 0) and silence limit
// (index 1), are written through the configuration channel, which is always ready;
// they should be written only while the block is idle. Reset (synchronous, active
// high) empties both queues, clears the frame sum and speech state and restores
// the register defaults of 2000 and 30.
`timescale 1ns / 1ps

module energy_vad_hangover_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  evh_pkg::in_item_t                  sample_item,
  output logic                               empty,
  input  logic                               pop,
  output evh_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [evh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [evh_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import evh_pkg::*;

  frame_t     fq_wdata;
  frame_t     fq_rdata;
  logic       fq_push;
  logic       fq_full;
  logic       fq_pop;
  logic       fq_empty;
  cfg_write_t cfg;

  // The registers are plain flops, so a write is always taken at once.
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Squaring and frame summing.
  evh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample_item (sample_item),
    .fq_push     (fq_push),
    .fq_data     (fq_wdata),
    .fq_full     (fq_full)
  );

  // Completed frames wait here so the two sides stall independently.
  evh_frame_fifo u_frame_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  // Threshold decision, hangover counting and result queue.
  evh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fq_empty (fq_empty),
    .fq_data  (fq_rdata),
    .fq_pop   (fq_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ===== design/evh_checker.sv =====
// Port-level checks on the result channel of the detector, bound to the top level.
`timescale 1ns / 1ps

module evh_checker (
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input evh_pkg::result_t result
);
  import evh_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result item changed while waiting");

  a_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.vad_event == EV_NONE || result.vad_event == EV_START ||
                result.vad_event == EV_END))
    else $error("unknown event code");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.vad_event == EV_START) |-> (result.frame_speech && result.in_speech_now))
    else $error("speech start without a speech frame");

  a_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.vad_event == EV_END) |-> (!result.frame_speech && !result.in_speech_now))
    else $error("speech end with segment still open");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_speech) |-> result.in_speech_now)
    else $error("speech frame outside a segment");

endmodule

bind energy_vad_hangover_unit evh_checker u_evh_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
